FILE: hw/rtl/vbs_pkg.sv
// Shared constants, types and saturation helpers for the vertex blend skinning block.
package vbs_pkg;

  localparam int BONE_COUNT_DEF = 256;
  localparam int BONE_SLOTS     = 4;
  localparam int COEFS_PER_BONE = 12;
  localparam int COEF_IDX_W     = 4;
  localparam int WEIGHT_ONE     = 32768;

  // Gravity magnitude is 98.1 * p, split as 98 * p + (p + 5) / 10.
  localparam int GRAV_INT      = 98;
  localparam int GRAV_ROUND    = 5;
  localparam int RECIP_W       = 26;
  localparam int RECIP_SHIFT   = 29;
  localparam int RECIP_TEN     = 53687092;
  // Smallest mass-gravity product whose force saturates at the negative limit.
  localparam int FORCE_SAT_P   = 21890761;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SKIN = 1'b1
  } vbs_op_t;

  typedef enum logic {
    CFG_GRAVITY = 1'b0,
    CFG_WEIGHT  = 1'b1
  } vbs_cfg_t;

  typedef struct packed {
    logic skin;
    logic grav;
  } vbs_flags_t;

  function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v[49:31] == {19{v[49]}}) begin
      r = v[31:0];
    end else if (v[49]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v[35:31] == {5{v[35]}}) begin
      r = v[31:0];
    end else if (v[35]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/vertex_blend_skinning.sv
// Top level of the vertex blend skinning pipeline with its bone matrix store.
//
// The input channel (in_valid/in_ready) carries two kinds of word. A load word
// writes one coefficient of a 3x4 bone matrix and produces nothing on the
// output. A skin word blends its rest position through up to four bones and
// gives one output word (out_valid/out_ready) with the position and the
// gravity force. The two configuration registers are written through
// cfg_write/cfg_index/cfg_data; the user must do so only while the block is
// idle, as the block itself does not enforce it. A skin word passes five
// register stages: store read, coefficient products, row sums, weighting,
// blend and saturation. One word is accepted every cycle unless the output
// stalls; the 48 coefficient banks, each read once per cycle, set that rate.
// A load followed directly by a skin word is seen by that skin word.
// Reset clears the stage valid bits and restores both registers to 256; the
// matrix store is not cleared and must be loaded before use.
// When the receiver stalls with a word waiting, the whole pipeline holds and
// in_ready falls; nothing is lost or repeated.
module vertex_blend_skinning import vbs_pkg::*; #(
  parameter int BONE_COUNT = BONE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [7:0]            matrix_index,
  input  logic [COEF_IDX_W-1:0] coef_index,
  input  logic signed [31:0]    coef_value,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  input  logic [15:0]           weight_a,
  input  logic [15:0]           weight_b,
  input  logic [15:0]           weight_c,
  input  logic [31:0]           bone_indices,
  input  logic [15:0]           bone_factor,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    skinned_x,
  output logic signed [31:0]    skinned_y,
  output logic signed [31:0]    skinned_z,
  output logic                  skinned_valid,
  output logic signed [31:0]    force_y
);

  localparam int AW = $clog2(BONE_COUNT);

  logic        adv;
  logic        accept;
  logic        load_wr;
  logic [15:0] gravity_factor;
  logic [15:0] vertex_weight;

  // Gravity force, recomputed continuously from the registers.
  logic [31:0]         f_p;
  logic                f_big;
  logic [31:0]         f_p98;
  logic [RECIP_W-1:0]  f_n;
  logic [2*RECIP_W-1:0] f_qprod;
  logic [31:0]         f_q;
  logic signed [31:0]  f_force;

  // Weight selection at the input.
  vbs_flags_t           fl_in;
  logic [17:0]          wsum;
  logic                 rem_pos;
  logic [15:0]          rem;
  logic [BONE_SLOTS-1:0] en;
  logic [BONE_SLOTS-1:0] inrange;
  logic [15:0]          wsel [BONE_SLOTS];

  logic                  v1;
  vbs_flags_t            fl1;
  logic signed [31:0]    pos1 [3];
  logic [15:0]           w1 [BONE_SLOTS];
  logic [BONE_SLOTS-1:0] use1;
  logic [31:0]           coef_rd [BONE_SLOTS][COEFS_PER_BONE];

  logic signed [63:0] prod [BONE_SLOTS][3][3];
  logic signed [31:0] trans [BONE_SLOTS][3];
  logic               v2;
  vbs_flags_t         fl2;
  logic signed [47:0] prod2 [BONE_SLOTS][3][3];
  logic signed [31:0] trans2 [BONE_SLOTS][3];
  logic [15:0]        w2 [BONE_SLOTS];

  logic signed [49:0] rsum [BONE_SLOTS][3];
  logic               v3;
  vbs_flags_t         fl3;
  logic signed [31:0] row3 [BONE_SLOTS][3];
  logic [15:0]        w3 [BONE_SLOTS];

  logic signed [48:0] wprod [BONE_SLOTS][3];
  logic               v4;
  vbs_flags_t         fl4;
  logic signed [33:0] contrib4 [BONE_SLOTS][3];

  logic signed [35:0] acc [3];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;
  assign load_wr  = accept && (opcode == OP_LOAD) &&
                    (coef_index < COEF_IDX_W'(COEFS_PER_BONE)) &&
                    ({1'b0, matrix_index} < 9'(BONE_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_factor <= 16'd256;
      vertex_weight  <= 16'd256;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GRAVITY: gravity_factor <= cfg_data;
        CFG_WEIGHT:  vertex_weight  <= cfg_data;
        default:     gravity_factor <= gravity_factor;
      endcase
    end
  end

  assign f_n     = {1'b0, f_p[RECIP_W-2:0]} + RECIP_W'(GRAV_ROUND);
  assign f_qprod = f_n * RECIP_W'(RECIP_TEN);

  // A register write reaches the force through f_p, then f_p98, f_q and f_big, then
  // f_force, and settles before any word accepted afterwards reaches the output.
  always_ff @(posedge clk) begin
    f_p     <= vertex_weight * gravity_factor;
    f_big   <= f_p >= 32'(FORCE_SAT_P);
    f_p98   <= 32'(f_p * 32'(GRAV_INT));
    f_q     <= 32'(f_qprod[2*RECIP_W-1:RECIP_SHIFT]);
    f_force <= f_big ? 32'sh8000_0000 : $signed(32'd0 - (f_p98 + f_q));
  end

  always_comb begin
    fl_in.skin = bone_factor != 16'(WEIGHT_ONE);
    fl_in.grav = bone_factor != 16'd0;
    wsum       = {2'b0, weight_a} + {2'b0, weight_b} + {2'b0, weight_c};
    rem_pos    = wsum < 18'(WEIGHT_ONE);
    rem        = 16'(18'(WEIGHT_ONE) - wsum);
    en[0]      = fl_in.skin && (weight_a != 16'd0);
    en[1]      = en[0] && (weight_b != 16'd0);
    en[2]      = en[1] && (weight_c != 16'd0);
    en[3]      = en[2] && rem_pos;
    wsel[0]    = weight_a;
    wsel[1]    = weight_b;
    wsel[2]    = weight_c;
    wsel[3]    = rem;
    for (int k = 0; k < BONE_SLOTS; k++) begin
      inrange[k] = {1'b0, bone_indices[8*k +: 8]} < 9'(BONE_COUNT);
    end
  end

  // Each bone slot keeps its own copy of the store, one bank per coefficient,
  // so all 48 coefficients of a vertex are read in the same cycle.
  for (genvar k = 0; k < BONE_SLOTS; k++) begin : g_slot
    for (genvar c = 0; c < COEFS_PER_BONE; c++) begin : g_coef
      logic [31:0] mem [BONE_COUNT];
      logic [31:0] rd;
      always_ff @(posedge clk) begin
        if (load_wr && coef_index == COEF_IDX_W'(c)) begin
          mem[matrix_index[AW-1:0]] <= coef_value;
        end
        if (adv) begin
          rd <= mem[bone_indices[8*k +: AW]];
        end
      end
      assign coef_rd[k][c] = rd;
    end
  end

  // Stage 1: operands and store read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= accept && (opcode == OP_SKIN);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fl1     <= fl_in;
      pos1[0] <= pos_x;
      pos1[1] <= pos_y;
      pos1[2] <= pos_z;
      for (int k = 0; k < BONE_SLOTS; k++) begin
        use1[k] <= en[k] && inrange[k];
        w1[k]   <= (en[k] && inrange[k]) ? wsel[k] : 16'd0;
      end
    end
  end

  // Unused slots have their coefficients forced to zero.
  always_comb begin
    for (int k = 0; k < BONE_SLOTS; k++) begin
      for (int r = 0; r < 3; r++) begin
        trans[k][r] = use1[k] ? $signed(coef_rd[k][r*4+3]) : 32'sd0;
        for (int c = 0; c < 3; c++) begin
          prod[k][r][c] = (use1[k] ? $signed(coef_rd[k][r*4+c]) : 32'sd0) * pos1[c];
        end
      end
    end
  end

  // Stage 2: coefficient products, floor-shifted to Q16.16.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fl2 <= fl1;
      for (int k = 0; k < BONE_SLOTS; k++) begin
        w2[k] <= w1[k];
        for (int r = 0; r < 3; r++) begin
          trans2[k][r] <= trans[k][r];
          for (int c = 0; c < 3; c++) begin
            prod2[k][r][c] <= prod[k][r][c][63:16];
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < BONE_SLOTS; k++) begin
      for (int r = 0; r < 3; r++) begin
        rsum[k][r] = 50'(prod2[k][r][0]) + 50'(prod2[k][r][1]) +
                     50'(prod2[k][r][2]) + 50'(trans2[k][r]);
      end
    end
  end

  // Stage 3: saturated row results.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fl3 <= fl2;
      for (int k = 0; k < BONE_SLOTS; k++) begin
        w3[k] <= w2[k];
        for (int r = 0; r < 3; r++) begin
          row3[k][r] <= sat50(rsum[k][r]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < BONE_SLOTS; k++) begin
      for (int r = 0; r < 3; r++) begin
        wprod[k][r] = row3[k][r] * $signed({1'b0, w3[k]});
      end
    end
  end

  // Stage 4: weighted contributions, floor-shifted by the weight scale.
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fl4 <= fl3;
      for (int k = 0; k < BONE_SLOTS; k++) begin
        for (int r = 0; r < 3; r++) begin
          contrib4[k][r] <= wprod[k][r][48:15];
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 36'(contrib4[0][r]) + 36'(contrib4[1][r]) +
               36'(contrib4[2][r]) + 36'(contrib4[3][r]);
    end
  end

  // Stage 5: output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      skinned_x     <= sat36(acc[0]);
      skinned_y     <= sat36(acc[1]);
      skinned_z     <= sat36(acc[2]);
      skinned_valid <= fl4.skin;
      force_y       <= fl4.grav ? f_force : 32'sd0;
    end
  end

endmodule

FILE: hw/rtl/vbs_checker.sv
// Port-level checker for the vertex blend skinning block, bound to the top level.
module vbs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] skinned_x,
  input logic signed [31:0] skinned_y,
  input logic signed [31:0] skinned_z,
  input logic               skinned_valid,
  input logic signed [31:0] force_y
);

  // A waiting output word must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(skinned_x) &&
      $stable(skinned_y) && $stable(skinned_z) && $stable(force_y))
    else $error("output word changed while stalled");

  // An unskinned vertex reports the origin.
  a_unskinned_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !skinned_valid |->
      skinned_x == 32'sd0 && skinned_y == 32'sd0 && skinned_z == 32'sd0)
    else $error("unskinned vertex with nonzero position");

  // Gravity only ever pulls downwards.
  a_force_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && force_y[31] == 1'b0 |-> force_y == 32'sd0)
    else $error("positive gravity force");

  // With the output register empty the input side is always open.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output word present after reset");

endmodule

bind vertex_blend_skinning vbs_checker u_vbs_checker (.*);

FILE: verif/vertex_blend_skinning_test.sv
// Self-checking testbench for the vertex blend skinning block.
module vertex_blend_skinning_test;
  import vbs_pkg::*;

  localparam int PHASE_COUNT  = 5;
  localparam int PHASE_ITEMS  = 110;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 200;
  // Gravity force at the reset setting of both registers.
  localparam logic signed [31:0] RESET_FORCE = -32'sd6429082;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               valid;
    logic signed [31:0] force_val;
  } skin_word_t;

  typedef struct {
    vbs_op_t            op;
    logic [7:0]         mi;
    logic [3:0]         ci;
    logic signed [31:0] cv, px, py, pz;
    logic [15:0]        wa, wb, wc;
    logic [31:0]        bones;
    logic [15:0]        bf;
    logic               pinned;
    skin_word_t         pin;
  } vbs_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = 1'b0;
  logic [7:0] matrix_index = '0;
  logic [3:0] coef_index = '0;
  logic signed [31:0] coef_value = '0, pos_x = '0, pos_y = '0, pos_z = '0;
  logic [15:0] weight_a = '0, weight_b = '0, weight_c = '0, bone_factor = '0;
  logic [31:0] bone_indices = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] skinned_x, skinned_y, skinned_z, force_y;
  logic skinned_valid;

  vertex_blend_skinning dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  logic signed [31:0] bone_mats [256][12];
  logic [11:0]        coefs_written [256];
  logic [7:0]         loaded_bones [$];
  logic [15:0]        grav_scale = 16'd256, vert_mass = 16'd256;

  skin_word_t pending_words [$];
  int  mismatches = 0;
  bit  send_idle = 1'b1, recv_idle = 1'b1, hold_request = 1'b0;
  int  words_sent = 0;
  int  quiet_cycles = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void blend_bone(inout longint acc[3], input logic [7:0] b,
                                     input longint p[3], input longint w);
    longint t;
    for (int r = 0; r < 3; r++) begin
      t = longint'(bone_mats[b][r*4+3]);
      for (int c = 0; c < 3; c++) t += (longint'(bone_mats[b][r*4+c]) * p[c]) >>> 16;
      t = clamp32(t);
      acc[r] += (t * w) >>> 15;
    end
  endfunction

  function automatic skin_word_t predict_skin(vbs_word_t w);
    skin_word_t res;
    longint acc[3] = '{0, 0, 0};
    longint p[3];
    longint wt[3];
    longint total = 0;
    longint mag;
    int j;
    p = '{longint'(w.px), longint'(w.py), longint'(w.pz)};
    wt = '{longint'(w.wa), longint'(w.wb), longint'(w.wc)};
    res.valid = (w.bf != 16'(WEIGHT_ONE));
    if (res.valid) begin
      for (j = 0; j < 3; j++) begin
        if (wt[j] == 0) break;
        blend_bone(acc, w.bones[8*j +: 8], p, wt[j]);
        total += wt[j];
      end
      if (j >= 3 && WEIGHT_ONE - total > 0)
        blend_bone(acc, w.bones[31:24], p, WEIGHT_ONE - total);
    end
    res.x = 32'(clamp32(acc[0]));
    res.y = 32'(clamp32(acc[1]));
    res.z = 32'(clamp32(acc[2]));
    res.force_val = '0;
    if (w.bf != 0) begin
      mag = longint'(vert_mass) * longint'(grav_scale) * 981;
      mag = (mag + 5) / 10;
      res.force_val = 32'(clamp32(-mag));
    end
    return res;
  endfunction

  function automatic void store_coef(vbs_word_t w);
    if (w.ci < COEFS_PER_BONE) begin
      bone_mats[w.mi][w.ci] = w.cv;
      coefs_written[w.mi][w.ci] = 1'b1;
      if (&coefs_written[w.mi] && !(w.mi inside {loaded_bones})) loaded_bones.push_back(w.mi);
    end
  endfunction

  task automatic write_reg(vbs_cfg_t idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_GRAVITY) grav_scale = val;
    else vert_mass = val;
  endtask

  // Drives one word from a falling edge and returns at a falling edge after acceptance.
  task automatic send_word(vbs_word_t w);
    in_valid     <= 1'b1;
    opcode       <= w.op;
    matrix_index <= w.mi;
    coef_index   <= w.ci;
    coef_value   <= w.cv;
    pos_x        <= w.px;
    pos_y        <= w.py;
    pos_z        <= w.pz;
    weight_a     <= w.wa;
    weight_b     <= w.wb;
    weight_c     <= w.wc;
    bone_indices <= w.bones;
    bone_factor  <= w.bf;
    do @(posedge clk); while (!in_ready);
    if (w.op == OP_LOAD) store_coef(w);
    else pending_words.push_back(w.pinned ? w.pin : predict_skin(w));
    words_sent++;
    @(negedge clk);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic vbs_word_t load_word(logic [7:0] mi, logic [3:0] ci, logic [31:0] cv);
    vbs_word_t w = '{op: OP_LOAD, default: '0};
    w.mi = mi;
    w.ci = ci;
    w.cv = cv;
    return w;
  endfunction

  function automatic vbs_word_t skin_word(logic [31:0] px, py, pz, logic [15:0] wa, wb, wc,
                                          logic [31:0] bones, logic [15:0] bf);
    vbs_word_t w = '{op: OP_SKIN, default: '0};
    w.px = px; w.py = py; w.pz = pz;
    w.wa = wa; w.wb = wb; w.wc = wc;
    w.bones = bones;
    w.bf = bf;
    return w;
  endfunction

  function automatic vbs_word_t pinned_word(vbs_word_t w, logic signed [31:0] x, y, z,
                                            logic v, logic signed [31:0] f);
    w.pinned = 1'b1;
    w.pin = '{x, y, z, v, f};
    return w;
  endfunction

  function automatic logic [31:0] rand_fixed();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(1, 12000));
    endcase
  endfunction

  function automatic vbs_word_t rand_skin();
    logic [31:0] bones;
    logic [15:0] bf;
    for (int k = 0; k < 4; k++)
      bones[8*k +: 8] = loaded_bones[$urandom_range(0, loaded_bones.size() - 1)];
    case ($urandom_range(0, 9))
      0:       bf = 16'(WEIGHT_ONE);
      1:       bf = '0;
      default: bf = 16'($urandom);
    endcase
    return skin_word(rand_fixed(), rand_fixed(), rand_fixed(),
                     (($urandom_range(0, 19) == 0) ? 16'd0 : rand_weight()),
                     rand_weight(), rand_weight(), bones, bf);
  endfunction

  task automatic run_random(int count);
    int target;
    logic [7:0] b;
    logic [3:0] order [12];
    target = words_sent + count;
    while (words_sent < target) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          // A whole matrix, written in a random order.
          b = 8'($urandom);
          foreach (order[i]) order[i] = 4'(i);
          order.shuffle();
          foreach (order[i]) send_word(load_word(b, order[i], rand_fixed()));
        end
        3: send_word(load_word(8'($urandom), 4'($urandom_range(12, 15)), $urandom));
        4: send_word(load_word(8'($urandom), 4'($urandom_range(0, 11)), rand_fixed()));
        default: send_word(rand_skin());
      endcase
    end
  endtask

  task automatic check_word(skin_word_t exp_word, skin_word_t got);
    if (got.x !== exp_word.x || got.y !== exp_word.y || got.z !== exp_word.z ||
        got.valid !== exp_word.valid || got.force_val !== exp_word.force_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Mismatch: expected x=%0d y=%0d z=%0d valid=%0b force=%0d, ",
                  "got x=%0d y=%0d z=%0d valid=%0b force=%0d"},
                 exp_word.x, exp_word.y, exp_word.z, exp_word.valid, exp_word.force_val,
                 got.x, got.y, got.z, got.valid, got.force_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output word x=%0d", skinned_x);
      end else begin
        check_word(pending_words.pop_front(),
                   '{skinned_x, skinned_y, skinned_z, skinned_valid, force_y});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always begin
    @(negedge clk);
    if (hold_request) begin
      out_ready <= 1'b0;
      repeat (LONG_HOLD) @(negedge clk);
      hold_request = 1'b0;
    end else if (recv_idle && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 10) - 1) @(negedge clk);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    vbs_word_t directed_rows [$];
    logic [15:0] phase_grav [PHASE_COUNT] = '{16'd256, 16'hffff, 16'd0, 16'd1, 16'd0};
    logic [15:0] phase_mass [PHASE_COUNT] = '{16'd256, 16'hffff, 16'hffff, 16'd0, 16'd0};
    foreach (coefs_written[i]) coefs_written[i] = '0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Bone 0 with unit diagonal and extreme x and y translations.
    directed_rows.push_back(load_word(8'd0, 4'd0, 32'h0001_0000));
    directed_rows.push_back(load_word(8'd0, 4'd1, 32'h0000_0000));
    directed_rows.push_back(load_word(8'd0, 4'd2, 32'h8000_0000));
    directed_rows.push_back(load_word(8'd0, 4'd3, 32'h7fff_ffff));
    directed_rows.push_back(load_word(8'd0, 4'd4, 32'h0000_0000));
    directed_rows.push_back(load_word(8'd0, 4'd5, 32'h0001_0000));
    directed_rows.push_back(load_word(8'd0, 4'd6, 32'h7fff_ffff));
    directed_rows.push_back(load_word(8'd0, 4'd7, 32'h8000_0000));
    directed_rows.push_back(load_word(8'd0, 4'd8, 32'hffff_ffff));
    directed_rows.push_back(load_word(8'd0, 4'd9, 32'h0000_8000));
    directed_rows.push_back(load_word(8'd0, 4'd10, 32'h0001_0000));
    directed_rows.push_back(load_word(8'd0, 4'd11, 32'h0001_0000));
    // Coefficient indexes past the matrix are dropped.
    directed_rows.push_back(load_word(8'd255, 4'd15, 32'hdead_beef));
    directed_rows.push_back(load_word(8'd0, 4'd12, 32'hffff_ffff));
    directed_rows.push_back(pinned_word(skin_word(32'h7fff_ffff, 32'h8000_0000, 32'h1,
        16'd32768, 16'd0, 16'd0, 32'h0, 16'd32768), 0, 0, 0, 1'b0, RESET_FORCE));
    directed_rows.push_back(pinned_word(skin_word(32'h0001_0000, 32'h0001_0000, 32'h1,
        16'd0, 16'hffff, 16'hffff, 32'h0, 16'd100), 0, 0, 0, 1'b1, RESET_FORCE));
    directed_rows.push_back(skin_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
        16'd32768, 16'd0, 16'd0, 32'h0, 16'd0));
    directed_rows.push_back(skin_word(32'h0002_0000, 32'hfffe_0000, 32'h0000_4000,
        16'd8192, 16'd8192, 16'd8192, 32'h0, 16'd1));
    directed_rows.push_back(skin_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        16'hffff, 16'hffff, 16'hffff, 32'h0, 16'hffff));
    directed_rows.push_back(skin_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
        16'd16384, 16'd0, 16'd5, 32'h0, 16'd32767));
    directed_rows.push_back(skin_word(32'h0000_0001, 32'hffff_ffff, 32'h0003_0000,
        16'd1, 16'd1, 16'd1, 32'h0, 16'd16384));

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      write_reg(CFG_GRAVITY, phase == PHASE_COUNT - 1 ? 16'($urandom) : phase_grav[phase]);
      write_reg(CFG_WEIGHT, phase == PHASE_COUNT - 1 ? 16'($urandom) : phase_mass[phase]);
      if (phase == 0) foreach (directed_rows[i]) send_word(directed_rows[i]);
      if (phase == 1) hold_request = 1'b1;
      if (phase == PHASE_COUNT - 1) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      run_random(PHASE_ITEMS);
      // The sender rests until every result of the phase is back.
      wait_drained();
    end

    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
